// ===== src/rbr_pkg.sv =====
package rbr_pkg;

  // table geometry
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned CntW      = $clog2(MaxPoints + 1);
  localparam int unsigned AddrW     = $clog2(NumChan * MaxPoints);

  // field widths
  localparam int unsigned StepW  = 16;
  localparam int unsigned LevelW = 8;
  localparam int unsigned PtsW   = 5;
  localparam int unsigned ChanW  = 2;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned EntryW = StepW + LevelW;

  // divider widths
  localparam int unsigned ProdW   = StepW + LevelW;
  localparam int unsigned DivCntW = $clog2(ProdW);

  // stream word widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 24;

  // opcodes
  localparam logic OpQuery = 1'b0;
  localparam logic OpLoad  = 1'b1;

  // channel codes
  localparam logic [ChanW-1:0] ChRed   = 2'd0;
  localparam logic [ChanW-1:0] ChGreen = 2'd1;
  localparam logic [ChanW-1:0] ChBlue  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegMaxStep    = 2'd0;
  localparam logic [1:0] RegPointsRed  = 2'd1;
  localparam logic [1:0] RegPointsGrn  = 2'd2;
  localparam logic [1:0] RegPointsBlue = 2'd3;

  // register reset values
  localparam logic [StepW-1:0] MaxStepRst = 16'hFFFF;
  localparam logic [PtsW-1:0]  PointsRst  = 5'd16;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  // one breakpoint
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [StepW-1:0]  step;
  } entry_t;

endpackage

// ===== src/rgb_breakpoint_ramp.sv =====
// rgb_breakpoint_ramp: three-channel piecewise-linear level ramp.
// slave stream: tuser = {channel, opcode}; opcode load writes one breakpoint
// (slot, point_step, point_level) into the table of the given channel, a
// query evaluates red, green and blue at the word's step.
// master stream: one word per query with the three levels; loads give none.
// cfg port: write max_step (index 0) or points per channel (1..3) while idle.
// loads: a load leaves the block idle, so tready stays high and loads can
// follow back to back.
// a query runs the channels one after another through one table read port
// and one restoring divider: per channel a scan over the n table points in
// use, a setup step with the multiply, a divide over the 24 quotient bits
// (skipped when the segment is flat or of zero width) and a finish step;
// tready is low meanwhile.
// the result sits in an output register; a new word is taken while it waits,
// but the next query stalls in its last finish cycle until the word is taken.
// reset: max_step 65535, 16 points per channel; the breakpoint table is not
// cleared and must be loaded before it is queried.
module rgb_breakpoint_ramp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // slot [3:0], point_step [19:4], point_level [27:20], step [43:28], zeros
  input  logic [rbr_pkg::InDataW-1:0]   s_axis_tdata,
  // opcode [0], channel [2:1]
  input  logic [rbr_pkg::InUserW-1:0]   s_axis_tuser,
  // master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // red_level [7:0], green_level [15:8], blue_level [23:16]
  output logic [rbr_pkg::OutDataW-1:0]  m_axis_tdata,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [rbr_pkg::StepW-1:0]     cfg_wdata_i
);
  import rbr_pkg::*;

  // input field unpacking
  logic                opcode;
  logic [ChanW-1:0]    in_chan;
  logic [SlotW-1:0]    in_slot;
  logic [StepW-1:0]    in_pstep;
  logic [LevelW-1:0]   in_plevel;
  logic [StepW-1:0]    in_step;
  logic                accept;

  assign opcode    = s_axis_tuser[0];
  assign in_chan   = s_axis_tuser[2:1];
  assign in_slot   = s_axis_tdata[3:0];
  assign in_pstep  = s_axis_tdata[19:4];
  assign in_plevel = s_axis_tdata[27:20];
  assign in_step   = s_axis_tdata[43:28];

  state_e state_q, state_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // configuration registers
  logic [StepW-1:0] max_step_q;
  logic [PtsW-1:0]  points_q [NumChan];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q <= MaxStepRst;
      for (int c = 0; c < int'(NumChan); c++) begin
        points_q[c] <= PointsRst;
      end
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegMaxStep:    max_step_q  <= cfg_wdata_i;
        RegPointsRed:  points_q[0] <= cfg_wdata_i[PtsW-1:0];
        RegPointsGrn:  points_q[1] <= cfg_wdata_i[PtsW-1:0];
        RegPointsBlue: points_q[2] <= cfg_wdata_i[PtsW-1:0];
        default: ;
      endcase
    end
  end

  // clamp a point count to 2..MaxPoints
  function automatic logic [CntW-1:0] clamp_pts(input logic [PtsW-1:0] p);
    logic [CntW-1:0] r;
    if (p < PtsW'(2)) begin
      r = CntW'(2);
    end else if (p > PtsW'(MaxPoints)) begin
      r = CntW'(MaxPoints);
    end else begin
      r = CntW'(p);
    end
    return r;
  endfunction

  // sequencer registers
  logic [ChanW-1:0]  ch_q;
  logic [CntW-1:0]   n_q;
  logic [CntW-1:0]   idx_q;
  logic [CntW-1:0]   didx_q;
  logic              dv_q;
  logic [StepW-1:0]  step_q;
  logic              is_zero_q;
  logic              is_max_q;
  entry_t            cur_q;
  entry_t            nxt_q;
  logic              nf_q;
  logic [StepW-1:0]  den_q;
  logic              neg_q;
  logic [ProdW-1:0]  quo_q;
  logic [StepW-1:0]  rem_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [LevelW-1:0] lvl_q [2];
  logic              m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  // breakpoint table
  entry_t            mem [NumChan * MaxPoints];
  logic              wr_en;
  logic [AddrW-1:0]  waddr;
  logic              rd_en;
  logic [AddrW-1:0]  raddr;
  entry_t            rdata_q;

  assign wr_en = accept && (opcode == OpLoad) && (in_chan <= ChBlue)
                 && ({1'b0, in_slot} < (SlotW + 1)'(MaxPoints));
  assign waddr = AddrW'(in_chan) * AddrW'(MaxPoints) + AddrW'(in_slot);
  assign rd_en = (state_q == ST_SCAN) && (idx_q < n_q);
  assign raddr = AddrW'(ch_q) * AddrW'(MaxPoints) + AddrW'(idx_q[IdxW-1:0]);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= '{level: in_plevel, step: in_pstep};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // segment setup arithmetic
  logic signed [StepW:0] diff;
  logic signed [StepW:0] den_s;
  logic [StepW-1:0]      diff_mag;
  logic [LevelW-1:0]     dlev;
  logic                  flat;

  assign diff     = $signed({1'b0, step_q}) - $signed({1'b0, cur_q.step});
  assign den_s    = $signed({1'b0, nxt_q.step}) - $signed({1'b0, cur_q.step});
  assign diff_mag = diff[StepW] ? StepW'(-diff) : diff[StepW-1:0];
  assign dlev     = (nxt_q.level > cur_q.level) ? nxt_q.level - cur_q.level
                                                : cur_q.level - nxt_q.level;
  assign flat     = (cur_q.step == nxt_q.step) || (cur_q.level == nxt_q.level);

  // divider step
  logic [StepW:0] rem_sh;
  logic           ge;

  assign rem_sh = {rem_q, quo_q[ProdW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  // final level with saturation
  logic signed [ProdW+1:0] res_s;
  logic [LevelW-1:0]       res;

  assign res_s = neg_q ? $signed({2'b00, ProdW'(cur_q.level)}) - $signed({2'b00, quo_q})
                       : $signed({2'b00, ProdW'(cur_q.level)}) + $signed({2'b00, quo_q});

  always_comb begin
    if (res_s < 0) begin
      res = '0;
    end else if (res_s > $signed((ProdW + 2)'(255))) begin
      res = '1;
    end else begin
      res = res_s[LevelW-1:0];
    end
  end

  logic fin_go;
  assign fin_go = (ch_q != ChBlue) || !m_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (opcode == OpQuery)) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_q >= n_q) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = flat ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_q == DivCntW'(ProdW - 1)) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_d = (ch_q == ChBlue) ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dv_q    <= 1'b0;
      ch_q    <= ChRed;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept && (opcode == OpQuery)) begin
            ch_q  <= ChRed;
            idx_q <= '0;
          end
          dv_q <= 1'b0;
        end
        ST_SCAN: begin
          dv_q <= rd_en;
          if (rd_en) idx_q <= idx_q + CntW'(1);
        end
        ST_FIN: begin
          if (fin_go && (ch_q != ChBlue)) begin
            ch_q  <= ch_q + ChanW'(1);
            idx_q <= '0;
          end
          dv_q <= 1'b0;
        end
        default: dv_q <= 1'b0;
      endcase
    end
  end

  // query setup and per-channel point count
  always_ff @(posedge clk_i) begin
    if (accept && (opcode == OpQuery)) begin
      step_q    <= in_step;
      is_zero_q <= (in_step == '0);
      is_max_q  <= (in_step >= max_step_q);
      n_q       <= clamp_pts(points_q[0]);
    end else if ((state_q == ST_FIN) && fin_go && (ch_q != ChBlue)) begin
      n_q <= clamp_pts(points_q[ch_q + ChanW'(1)]);
    end
  end

  // segment search on the data of the previous read
  always_ff @(posedge clk_i) begin
    if (rd_en) didx_q <= idx_q;
    if (dv_q) begin
      if (is_zero_q) begin
        if (didx_q == CntW'(0)) cur_q <= rdata_q;
        if (didx_q == CntW'(1)) nxt_q <= rdata_q;
      end else if (is_max_q) begin
        if (didx_q == n_q - CntW'(1)) begin
          cur_q <= rdata_q;
          nxt_q <= rdata_q;
        end
      end else if (didx_q == CntW'(0)) begin
        // entry 0 is the fallback for both ends
        cur_q <= rdata_q;
        nxt_q <= rdata_q;
        nf_q  <= (rdata_q.step > step_q);
      end else begin
        if (rdata_q.step <= step_q) cur_q <= rdata_q;
        if ((rdata_q.step > step_q) && !nf_q) begin
          nxt_q <= rdata_q;
          nf_q  <= 1'b1;
        end
      end
    end
  end

  // multiply, then restoring divide one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_SETUP: begin
        den_q     <= den_s[StepW] ? StepW'(-den_s) : den_s[StepW-1:0];
        neg_q     <= diff[StepW] ^ den_s[StepW] ^ (nxt_q.level < cur_q.level);
        quo_q     <= flat ? '0 : ProdW'(diff_mag) * ProdW'(dlev);
        rem_q     <= '0;
        div_cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q     <= ge ? StepW'(rem_sh - {1'b0, den_q}) : rem_sh[StepW-1:0];
        quo_q     <= {quo_q[ProdW-2:0], ge};
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
      default: ;
    endcase
  end

  // per-channel results
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FIN) && (ch_q != ChBlue)) begin
      lvl_q[ch_q[0]] <= res;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == ST_FIN) && (ch_q == ChBlue) && fin_go) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FIN) && (ch_q == ChBlue) && fin_go) begin
      m_data_q <= {res, lvl_q[1], lvl_q[0]};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // checks
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (den_q != '0))
    else $error("divide by zero segment width");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |-> (didx_q < n_q))
    else $error("table read beyond points in use");

  a_chan_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (ch_q <= ChBlue))
    else $error("channel counter out of range");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && (ch_q == ChBlue) && m_valid_q && !m_axis_tready)
      |=> (state_q == ST_FIN) && m_valid_q)
    else $error("result overwritten while output stalled");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rbr_pkg::*;

  // load aimed at the unused fourth channel code, dropped by the block
  localparam logic [ChanW-1:0] ChNone = 2'd3;
  localparam int unsigned WordTarget = 1600;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned CycleLimit = 2_000_000;

  // red in the low byte, as on the master stream
  typedef struct packed {
    logic [LevelW-1:0] blue;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] red;
  } levels_t;

  // tracks the breakpoint tables and registers, predicts the three levels per query
  class ramp_checker;
    logic [StepW-1:0]  bp_step  [NumChan][MaxPoints];
    logic [LevelW-1:0] bp_level [NumChan][MaxPoints];
    logic [StepW-1:0]  max_step;
    logic [PtsW-1:0]   points [NumChan];
    levels_t           pending_levels [$];
    int                errors;

    function new();
      max_step = MaxStepRst;
      foreach (points[c]) points[c] = PointsRst;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [StepW-1:0] val);
      case (idx)
        RegMaxStep:    max_step = val;
        RegPointsRed:  points[ChRed] = val[PtsW-1:0];
        RegPointsGrn:  points[ChGreen] = val[PtsW-1:0];
        RegPointsBlue: points[ChBlue] = val[PtsW-1:0];
        default: ;
      endcase
    endfunction

    // level of one channel at step q
    function logic [LevelW-1:0] interp_level(int ch, logic [StepW-1:0] q);
      int n, i, cur, nxt;
      longint ci, ni, cv, nv, dv, quo, r;
      n = points[ch];
      if (n < 2) n = 2;
      if (n > MaxPoints) n = MaxPoints;
      if (q == 0) begin
        cur = 0;
        nxt = 1;
      end else if (q >= max_step) begin
        cur = n - 1;
        nxt = n - 1;
      end else begin
        // last point at or before q, first point after q; entry 0 if none
        cur = 0;
        nxt = 0;
        for (i = 0; i < n; i++) if (bp_step[ch][i] <= q) cur = i;
        for (i = n - 1; i >= 0; i--) if (bp_step[ch][i] > q) nxt = i;
      end
      ci = bp_step[ch][cur];
      ni = bp_step[ch][nxt];
      cv = bp_level[ch][cur];
      nv = bp_level[ch][nxt];
      if (ci == ni || cv == nv) return cv[LevelW-1:0];
      dv = (nv > cv) ? nv - cv : cv - nv;
      quo = ((longint'(q) - ci) * dv) / (ni - ci);
      r = (nv > cv) ? cv + quo : cv - quo;
      if (r < 0) r = 0;
      if (r > 255) r = 255;
      return r[LevelW-1:0];
    endfunction

    // accepted slave word: table write or a new expected result
    function void note_word(logic [InUserW-1:0] user, logic [InDataW-1:0] data);
      logic [ChanW-1:0] ch;
      levels_t want;
      ch = user[2:1];
      if (user[0] == OpLoad) begin
        if (ch != ChNone) begin
          bp_step[ch][data[3:0]]  = data[19:4];
          bp_level[ch][data[3:0]] = data[27:20];
        end
      end else begin
        want.red   = interp_level(ChRed, data[43:28]);
        want.green = interp_level(ChGreen, data[43:28]);
        want.blue  = interp_level(ChBlue, data[43:28]);
        pending_levels.push_back(want);
      end
    endfunction

    function void compare_level(string name, logic [LevelW-1:0] want, logic [LevelW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s level mismatch: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [OutDataW-1:0] data);
      levels_t got, want;
      got = data;
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got %h", $time, data);
        errors++;
        return;
      end
      want = pending_levels.pop_front();
      compare_level("red", want.red, got.red);
      compare_level("green", want.green, got.green);
      compare_level("blue", want.blue, got.blue);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // slot, point_step, point_level, step, zero pad
  logic [InDataW-1:0]   s_axis_tdata = '0;
  // opcode, channel
  logic [InUserW-1:0]   s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // red_level, green_level, blue_level
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [1:0]           cfg_addr_i = RegMaxStep;
  logic [StepW-1:0]     cfg_wdata_i = '0;

  ramp_checker ramp;
  bit          steady = 1'b0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;

  rgb_breakpoint_ramp i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) ramp.check_word(m_axis_tdata);
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one slave word, with random idle cycles ahead of it
  task automatic send_word(logic op, logic [ChanW-1:0] ch, logic [SlotW-1:0] slot,
                           logic [StepW-1:0] pstep, logic [LevelW-1:0] plevel,
                           logic [StepW-1:0] q);
    while (!steady && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, q, plevel, pstep, slot};
    s_axis_tuser  <= {ch, op};
    do @(posedge clk_i); while (!s_axis_tready);
    ramp.note_word(s_axis_tuser, s_axis_tdata);
    if (!(op == OpLoad && ch == ChNone)) words_sent++;
  endtask

  task automatic load_point(logic [ChanW-1:0] ch, int slot, logic [StepW-1:0] s,
                            logic [LevelW-1:0] lv);
    send_word(OpLoad, ch, slot, s, lv, $urandom);
  endtask

  // unused load fields carry random bits on queries
  task automatic ask_levels(logic [StepW-1:0] q);
    send_word(OpQuery, $urandom_range(0, 3), $urandom, $urandom, $urandom, q);
  endtask

  // hold off until every result is out and the block has settled
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (ramp.pending_levels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write all four registers back to back while the block is idle
  task automatic program_regs(logic [StepW-1:0] ms, logic [PtsW-1:0] pr,
                              logic [PtsW-1:0] pg, logic [PtsW-1:0] pb);
    logic [1:0]       idx [4];
    logic [StepW-1:0] val [4];
    int k;
    idx = '{RegMaxStep, RegPointsRed, RegPointsGrn, RegPointsBlue};
    val = '{ms, StepW'(pr), StepW'(pg), StepW'(pb)};
    drain_results();
    for (k = 0; k < 4; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx[k];
      cfg_wdata_i <= val[k];
      @(posedge clk_i);
      ramp.set_reg(idx[k], val[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // fill one channel: ascending with random spacing and levels, or pure noise
  task automatic load_table(logic [ChanW-1:0] ch, bit noisy);
    int unsigned s, span;
    logic [LevelW-1:0] lv;
    int i;
    s = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3000) : 0;
    span = ($urandom_range(0, 2) == 0) ? 40 : 4300;
    lv = $urandom;
    for (i = 0; i < MaxPoints; i++) begin
      if (noisy) begin
        load_point(ch, i, $urandom, $urandom);
      end else begin
        load_point(ch, i, (s > 65535) ? 16'hFFFF : s[StepW-1:0], lv);
        s += $urandom_range(0, span);
        case ($urandom_range(0, 5))
          0: ;
          1: lv = '0;
          2: lv = '1;
          default: lv = $urandom;
        endcase
      end
    end
  endtask

  // query steps lean toward breakpoints and the max_step edge
  function automatic logic [StepW-1:0] pick_step();
    int ch, sl;
    ch = $urandom_range(0, NumChan - 1);
    sl = $urandom_range(0, MaxPoints - 1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ramp.max_step;
      2: return ramp.max_step - 1;
      3: return '1;
      4, 5, 6: return ramp.bp_step[ch][sl] + $urandom_range(0, 6) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [StepW-1:0] pick_max_step();
    logic [StepW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '1;
      1: v = 1;
      2: v = $urandom_range(1, 65535);
      3: v = ramp.bp_step[$urandom_range(0, NumChan - 1)][$urandom_range(0, MaxPoints - 1)];
      default: v = $urandom_range(20000, 65535);
    endcase
    return (v == 0) ? 1 : v;
  endfunction

  // counts below two and above sixteen appear now and then
  function automatic logic [PtsW-1:0] pick_points();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1);
      1: return $urandom_range(17, 31);
      2: return MaxPoints;
      default: return $urandom_range(2, MaxPoints);
    endcase
  endfunction

  // stimulus
  initial begin
    int i, ep, nq, k;
    ramp = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // red rises over the full step range, green falls with a flat segment
    // and starts late, blue swings between the level extremes
    for (i = 0; i < MaxPoints; i++) begin
      load_point(ChRed, i, i * 4369, i * 17);
      load_point(ChGreen, i, 1000 + i * 3000, (i == 5) ? 8'd187 : 8'(255 - i * 17));
      load_point(ChBlue, i, (i >= 9) ? (i - 1) * 4000 : i * 4000, (i % 2) ? 8'd255 : 8'd0);
    end
    ask_levels(0);
    ask_levels(4369);
    ask_levels(4370);
    ask_levels(65534);
    ask_levels(65535);
    ask_levels(500);
    ask_levels(14500);
    ask_levels(50000);
    ask_levels(32000);
    ask_levels(32001);
    // dropped load on the unused channel code
    load_point(ChNone, 0, 16'h1234, 8'h56);
    ask_levels(4000);
    // green out of order: next point missing and zero-width segment
    load_point(ChGreen, 15, 1000, 9);
    ask_levels(50000);
    // blue first point beyond the second: saturation and no current point
    load_point(ChBlue, 0, 5000, 10);
    ask_levels(0);
    ask_levels(100);
    // max_step at its floor and point counts out of range
    program_regs(1, 0, 1, 31);
    ask_levels(0);
    ask_levels(1);
    ask_levels(2);
    program_regs(16'hFFFF, 2, MaxPoints, 5);
    ask_levels(3000);
    ask_levels(61000);

    // random episodes: settings, table reloads in most of them, then a burst of queries
    ep = 0;
    while (words_sent < WordTarget) begin
      steady = (ep >= 5 && ep < 9);
      program_regs(pick_max_step(), pick_points(), pick_points(), pick_points());
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ;
        4, 5, 6, 7: load_table($urandom_range(0, NumChan - 1), 1'b0);
        8: load_table($urandom_range(0, NumChan - 1), 1'b1);
        default: begin
          load_table(ChRed, 1'b0);
          load_table(ChGreen, 1'b0);
          load_table(ChBlue, 1'b0);
        end
      endcase
      nq = $urandom_range(20, 60);
      for (k = 0; k < nq; k++) begin
        if ($urandom_range(0, 11) == 0)
          load_point($urandom_range(0, 3), $urandom_range(0, MaxPoints - 1), $urandom, $urandom);
        else
          ask_levels(pick_step());
        if ($urandom_range(0, 99) == 0) drain_results();
      end
      ep++;
    end

    drain_results();
    if (ramp.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
